FILE: design/sphe_pkg.sv
// types, constants and microcode program of the stereo peak-hold envelope follower
package sphe_pkg;

	localparam int SAMPLE_W = 24;
	localparam int LEVEL_W  = 24;
	localparam int HOLD_W   = 16;
	localparam int COEFF_W  = 17;
	localparam int CFG_IDX_W = 2;
	localparam int PC_W     = 4;
	localparam int PROD_W   = LEVEL_W + COEFF_W;
	localparam int Q16_SHIFT = 16;

	localparam logic [COEFF_W-1:0] Q16_ONE = COEFF_W'(65536);
	localparam logic [PROD_W-1:0]  Q16_HALF = PROD_W'(32768);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_SAMPLES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEFF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINK_AMOUNT   = 2'd2;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [LEVEL_W-1:0]         level_t;
	typedef logic [HOLD_W-1:0]          hold_t;
	typedef logic [COEFF_W-1:0]         coeff_t;
	typedef logic [PROD_W-1:0]          prod_t;
	typedef logic [PC_W-1:0]            pc_t;

	// datapath operations
	typedef enum logic [2:0] {
		OP_EVAL,
		OP_MUL,
		OP_DEC,
		OP_LINK,
		OP_RAISE,
		OP_DONE
	} op_t;

	// jump conditions
	typedef enum logic [1:0] {
		COND_NONE,
		COND_SETTLED,
		COND_NO_LINK
	} cond_t;

	typedef struct packed {
		op_t   op;
		logic  ch;
		cond_t cond;
		pc_t   target;
	} ucode_t;

	// program step addresses
	localparam pc_t STEP_EVAL0 = 4'd0;
	localparam pc_t STEP_MUL0  = 4'd1;
	localparam pc_t STEP_DEC0  = 4'd2;
	localparam pc_t STEP_EVAL1 = 4'd3;
	localparam pc_t STEP_MUL1  = 4'd4;
	localparam pc_t STEP_DEC1  = 4'd5;
	localparam pc_t STEP_LINK  = 4'd6;
	localparam pc_t STEP_MUL2  = 4'd7;
	localparam pc_t STEP_RAISE = 4'd8;
	localparam pc_t STEP_DONE  = 4'd9;

	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t w;
		unique case (pc)
			STEP_EVAL0: w = '{OP_EVAL,  1'b0, COND_SETTLED, STEP_EVAL1};
			STEP_MUL0:  w = '{OP_MUL,   1'b0, COND_NONE,    STEP_EVAL0};
			STEP_DEC0:  w = '{OP_DEC,   1'b0, COND_NONE,    STEP_EVAL0};
			STEP_EVAL1: w = '{OP_EVAL,  1'b1, COND_SETTLED, STEP_LINK};
			STEP_MUL1:  w = '{OP_MUL,   1'b1, COND_NONE,    STEP_EVAL0};
			STEP_DEC1:  w = '{OP_DEC,   1'b1, COND_NONE,    STEP_EVAL0};
			STEP_LINK:  w = '{OP_LINK,  1'b0, COND_NO_LINK, STEP_DONE};
			STEP_MUL2:  w = '{OP_MUL,   1'b0, COND_NONE,    STEP_EVAL0};
			STEP_RAISE: w = '{OP_RAISE, 1'b0, COND_NONE,    STEP_EVAL0};
			default:    w = '{OP_DONE,  1'b0, COND_NONE,    STEP_EVAL0};
		endcase
		return w;
	endfunction

	// full-wave rectify; the most negative sample maps to 8388608
	function automatic level_t rectify(input sample_t s);
		return s[SAMPLE_W-1] ? level_t'(-s) : level_t'(s);
	endfunction

	function automatic coeff_t sat_q16(input coeff_t v);
		return (v > Q16_ONE) ? Q16_ONE : v;
	endfunction

endpackage

FILE: design/sphe_if.sv
// stream interfaces for the sample and envelope channels
interface sphe_in_if import sphe_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t left_sample;
	sample_t right_sample;

	modport source(output valid, output left_sample, output right_sample, input ready);
	modport sink(input valid, input left_sample, input right_sample, output ready);
endinterface

interface sphe_out_if import sphe_pkg::*; ();
	logic   valid;
	logic   ready;
	level_t left_envelope;
	level_t right_envelope;

	modport source(output valid, output left_envelope, output right_envelope, input ready);
	modport sink(input valid, input left_envelope, input right_envelope, output ready);
endinterface

FILE: design/stereo_peak_hold_envelope_top.sv
// stereo peak-hold envelope follower, microcoded over one shared multiplier
//
// usage
//   samples: one word is a signed 24-bit left and right side-chain sample
//   envelopes: one word per sample word, unsigned left and right envelope
//   cfg port: cfg_we, cfg_index, cfg_data; index 0 hold_samples, 1 release_coeff,
//   2 link_amount; write only while the block is idle, index 3 is ignored
// timing
//   a word runs through a ten-step microprogram; steps that are not needed are
//   jumped over, so with no decay and no link only the evaluate steps of both
//   channels, the link step and the done step run; each decaying channel adds a
//   multiply and a decrement step, and linking adds a multiply and a raise step.
//   the single 24x17 multiplier and its product register set those extra steps.
//   a new word is taken in the cycle the last step finishes, so words follow back
//   to back; the envelope word is valid in the cycle after that final step
// reset
//   peaks and hold counters clear to zero, release_coeff goes to one, hold
//   and link go to zero; the block comes out of reset ready
// stall
//   the result sits in an output register; the next item is worked on while
//   it waits, and the sequencer parks on its final step until the register frees
module stereo_peak_hold_envelope_top
	import sphe_pkg::*;
#(
	parameter int CHANNELS = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEFF_W-1:0]   cfg_data,
	sphe_in_if.sink              samples,
	sphe_out_if.source           envelopes
);

	// configuration
	hold_t  hold_samples_q;
	coeff_t release_coeff_q;
	coeff_t link_amount_q;

	// per-channel tracking state
	level_t peak_q [CHANNELS];
	hold_t  hold_q [CHANNELS];

	// sequencer
	logic   busy_q;
	pc_t    pc_q;
	ucode_t uc;

	// working registers
	level_t smp_q [2];
	level_t env_q [2];
	level_t mul_a_q;
	coeff_t mul_b_q;
	prod_t  prod_q;
	logic   lo_q;

	// output register
	logic   out_valid_q;
	level_t out_left_q;
	level_t out_right_q;

	// step decode
	logic   live;
	level_t pk;
	hold_t  hl;
	level_t smp;
	logic   above;
	logic   settled;
	coeff_t rel_sat;
	coeff_t link_sat;
	logic   no_link;
	logic   lo_sel;
	level_t link_diff;
	level_t step_val;
	logic   take_jump;
	logic   out_free;
	logic   done_go;
	logic   accept;

	always_comb begin
		uc       = ucode_rom(pc_q);
		live     = int'(uc.ch) < CHANNELS;
		pk       = peak_q[uc.ch];
		hl       = hold_q[uc.ch];
		smp      = smp_q[uc.ch];
		above    = pk > smp;
		// nothing left to decay: new peak, still holding, or channel absent
		settled  = !live || !above || (hl != '0);
		rel_sat  = sat_q16(release_coeff_q);
		link_sat = sat_q16(link_amount_q);
		no_link  = (CHANNELS < 2) || (link_sat == '0);
		lo_sel   = !(env_q[0] < env_q[1]);
		link_diff = lo_sel ? (env_q[0] - env_q[1]) : (env_q[1] - env_q[0]);
		// rounded step never exceeds its difference, so the top bits are zero
		step_val = prod_q[Q16_SHIFT +: LEVEL_W];
		case (uc.cond)
			COND_SETTLED: take_jump = settled;
			COND_NO_LINK: take_jump = no_link;
			default:      take_jump = 1'b0;
		endcase
	end

	assign out_free = !out_valid_q || envelopes.ready;
	assign done_go  = busy_q && (uc.op == OP_DONE) && out_free;
	assign samples.ready = !busy_q || done_go;
	assign accept   = samples.valid && samples.ready;

	assign envelopes.valid          = out_valid_q;
	assign envelopes.left_envelope  = out_left_q;
	assign envelopes.right_envelope = out_right_q;

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q          <= 1'b0;
			pc_q            <= STEP_EVAL0;
			out_valid_q     <= 1'b0;
			hold_samples_q  <= '0;
			release_coeff_q <= Q16_ONE;
			link_amount_q   <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				peak_q[i] <= '0;
				hold_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_HOLD_SAMPLES:  hold_samples_q  <= cfg_data[HOLD_W-1:0];
					REG_RELEASE_COEFF: release_coeff_q <= cfg_data;
					REG_LINK_AMOUNT:   link_amount_q   <= cfg_data;
					default: ;
				endcase
			end

			if (accept) begin
				busy_q <= 1'b1;
				pc_q   <= STEP_EVAL0;
			end else if (done_go) begin
				busy_q <= 1'b0;
				pc_q   <= STEP_EVAL0;
			end else if (busy_q && uc.op != OP_DONE) begin
				pc_q <= take_jump ? uc.target : pc_q + 1'b1;
			end

			if (done_go)
				out_valid_q <= 1'b1;
			else if (envelopes.ready)
				out_valid_q <= 1'b0;

			if (busy_q && live) begin
				unique case (uc.op)
					OP_EVAL: begin
						if (!above) begin
							peak_q[uc.ch] <= smp;
							hold_q[uc.ch] <= hold_samples_q;
						end else if (hl != '0) begin
							hold_q[uc.ch] <= hl - 1'b1;
						end
					end
					OP_DEC: peak_q[uc.ch] <= pk - step_val;
					default: ;
				endcase
			end
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q[0] <= rectify(samples.left_sample);
			smp_q[1] <= rectify(samples.right_sample);
		end
		if (busy_q) begin
			unique case (uc.op)
				OP_EVAL: begin
					env_q[uc.ch] <= !live ? '0 : (above ? pk : smp);
					mul_a_q      <= pk - smp;
					mul_b_q      <= rel_sat;
				end
				OP_MUL:  prod_q <= PROD_W'(mul_a_q) * PROD_W'(mul_b_q) + Q16_HALF;
				OP_DEC:  env_q[uc.ch] <= pk - step_val;
				OP_LINK: begin
					lo_q    <= lo_sel;
					mul_a_q <= link_diff;
					mul_b_q <= link_sat;
				end
				OP_RAISE: env_q[lo_q] <= env_q[lo_q] + step_val;
				default: ;
			endcase
		end
		if (done_go) begin
			out_left_q  <= env_q[0];
			out_right_q <= env_q[1];
		end
	end

endmodule

FILE: sim/sphe_envelope_checker.sv
// envelope checker: predicts each envelope word from the accepted sample words and compares
module sphe_envelope_checker
	import sphe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEFF_W-1:0]   cfg_data,
	sphe_in_if                   samples,
	sphe_out_if                  envelopes,
	output int                   mismatches,
	output int                   pending
);

	typedef struct packed {
		level_t left;
		level_t right;
	} env_pair_t;

	hold_t     cfg_hold;
	coeff_t    cfg_release;
	coeff_t    cfg_link;
	level_t    peak_lvl[2];
	hold_t     hold_cnt[2];
	env_pair_t env_q[$];
	env_pair_t want;

	// rounded q16 product, coefficient already limited to one
	function automatic level_t q16_mul(input level_t diff, input coeff_t k);
		logic [63:0] p;
		p = 64'(diff) * 64'(k) + 64'd32768;
		return level_t'(p >> Q16_SHIFT);
	endfunction

	function automatic level_t magnitude(input sample_t s);
		logic [SAMPLE_W:0] v;
		v = {1'b0, s};
		if (s[SAMPLE_W-1])
			v = 25'h1000000 - v;
		return level_t'(v);
	endfunction

	function automatic level_t follow_channel(input int ch, input level_t mag);
		coeff_t rel;
		rel = (cfg_release > Q16_ONE) ? Q16_ONE : cfg_release;
		if (peak_lvl[ch] > mag) begin
			if (hold_cnt[ch] != '0) begin
				hold_cnt[ch] = hold_cnt[ch] - 1'b1;
				return peak_lvl[ch];
			end
			peak_lvl[ch] = peak_lvl[ch] - q16_mul(peak_lvl[ch] - mag, rel);
			return peak_lvl[ch];
		end
		peak_lvl[ch] = mag;
		hold_cnt[ch] = cfg_hold;
		return mag;
	endfunction

	function automatic env_pair_t predict_envelopes(input sample_t l, input sample_t r);
		env_pair_t e;
		coeff_t    lk;
		lk = (cfg_link > Q16_ONE) ? Q16_ONE : cfg_link;
		e.left  = follow_channel(0, magnitude(l));
		e.right = follow_channel(1, magnitude(r));
		if (lk != '0) begin
			if (e.left < e.right)
				e.left = e.left + q16_mul(e.right - e.left, lk);
			else
				e.right = e.right + q16_mul(e.left - e.right, lk);
		end
		return e;
	endfunction

	task automatic report(input string field, input level_t exp_v, input level_t act_v);
		mismatches++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_hold    = '0;
			cfg_release = Q16_ONE;
			cfg_link    = '0;
			peak_lvl    = '{default: '0};
			hold_cnt    = '{default: '0};
			env_q.delete();
			mismatches  = 0;
			pending     = 0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_HOLD_SAMPLES:  cfg_hold = hold_t'(cfg_data);
					REG_RELEASE_COEFF: cfg_release = cfg_data;
					REG_LINK_AMOUNT:   cfg_link = cfg_data;
					default: ;
				endcase
			end
			if (envelopes.valid && envelopes.ready) begin
				if (env_q.size() == 0) begin
					mismatches++;
					$display("%0t: envelope word with none expected, actual %0d %0d",
						$time, envelopes.left_envelope, envelopes.right_envelope);
				end else begin
					want = env_q.pop_front();
					if (envelopes.left_envelope !== want.left)
						report("left_envelope", want.left, envelopes.left_envelope);
					if (envelopes.right_envelope !== want.right)
						report("right_envelope", want.right, envelopes.right_envelope);
				end
			end
			if (samples.valid && samples.ready)
				env_q.push_back(predict_envelopes(samples.left_sample, samples.right_sample));
			pending = env_q.size();
		end
	end

endmodule

FILE: sim/stereo_peak_hold_envelope_top_tb.sv
// testbench top: sample word stimulus, register writes and the verdict
module stereo_peak_hold_envelope_top_tb;
	import sphe_pkg::*;

	localparam int HALF_PERIOD      = 6;
	localparam int PHASES           = 8;
	localparam int WORDS_PER_PHASE  = 150;
	localparam int LONG_HOLD_OFF    = 300;
	// a few times the longest microprogram pass
	localparam int DRAIN_CYCLES     = 40;
	localparam int RUN_LIMIT_CYCLES = 400000;
	localparam int RANDOM_PICK      = -1;

	// index past the register list, the block must ignore it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// register settings per random phase, extremes included
	localparam int PH_HOLD[PHASES]    = '{0, 4, 65535, 1, RANDOM_PICK, 0, RANDOM_PICK, 2};
	localparam int PH_RELEASE[PHASES] = '{65536, 8192, 1, 131071, RANDOM_PICK, 0,
		RANDOM_PICK, 300};
	localparam int PH_LINK[PHASES]    = '{0, 32768, 65536, 131071, RANDOM_PICK, 1,
		RANDOM_PICK, 0};

	localparam sample_t CORNERS[5] = '{24'sh000000, 24'sh7fffff, 24'sh800000, 24'shffffff,
		24'sh000001};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COEFF_W-1:0]   cfg_data = '0;

	// idle and stall odds in percent, changed per phase
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	// each toggle asks the receiver for one long hold-off
	logic hold_off_tog = 1'b0;

	int mismatches;
	int pending;

	// per-channel amplitude of the shaped random signal
	int unsigned amp[2] = '{0, 0};

	sphe_in_if  samples_ch();
	sphe_out_if envelopes_ch();

	always #HALF_PERIOD clk = ~clk;

	stereo_peak_hold_envelope_top #(
		.CHANNELS(2)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.samples  (samples_ch),
		.envelopes(envelopes_ch)
	);

	sphe_envelope_checker env_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (samples_ch),
		.envelopes (envelopes_ch),
		.mismatches(mismatches),
		.pending   (pending)
	);

	// offer one sample word; valid stays high into the next word unless a gap is drawn
	task automatic offer_word(input sample_t l, input sample_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			samples_ch.valid <= 1'b0;
			@(negedge clk);
		end
		samples_ch.valid        <= 1'b1;
		samples_ch.left_sample  <= l;
		samples_ch.right_sample <= r;
		@(posedge clk);
		while (!samples_ch.ready)
			@(posedge clk);
	endtask

	// stop offering and wait until every envelope word has come back
	task automatic settle();
		@(negedge clk);
		samples_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= coeff_t'(val);
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// registers only change with the block idle
	task automatic configure(input int unsigned hold, input int unsigned rel,
			input int unsigned link);
		settle();
		write_reg(REG_HOLD_SAMPLES, hold);
		write_reg(REG_RELEASE_COEFF, rel);
		write_reg(REG_LINK_AMOUNT, link);
	endtask

	// mostly bursts that jump up and then fade, so peaks get held and released;
	// the rest is full-range noise and corner values
	function automatic sample_t next_sample(input int ch);
		int unsigned mag;
		sample_t     s;
		case ($urandom_range(19))
			0: return sample_t'($urandom);
			1: return CORNERS[$urandom_range(4)];
			default: begin
				if ($urandom_range(15) == 0)
					amp[ch] = $urandom_range(8388608);
				else
					amp[ch] = amp[ch] - (amp[ch] >> 5);
				mag = $urandom_range(amp[ch]);
				s = sample_t'(mag);
				return $urandom_range(1) ? sample_t'(-s) : s;
			end
		endcase
	endfunction

	// receiver: random stalls, plus a long hold-off whenever the toggle flips
	initial begin
		int   stall_left;
		logic tog_seen;
		stall_left = 0;
		tog_seen = 1'b0;
		envelopes_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_tog != tog_seen) begin
				tog_seen = hold_off_tog;
				stall_left = LONG_HOLD_OFF;
			end
			if (stall_left > 0) begin
				stall_left--;
				envelopes_ch.ready <= 1'b0;
			end else begin
				envelopes_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// stimulus and verdict
	initial begin
		int unsigned hold_v;
		int unsigned rel_v;
		int unsigned link_v;
		samples_ch.valid = 1'b0;
		samples_ch.left_sample = '0;
		samples_ch.right_sample = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: no hold, release in one step, no link
		offer_word(24'sh000000, 24'sh000000);
		// largest positive and most negative sample
		offer_word(24'sh7fffff, 24'sh800000);
		offer_word(24'sh800000, 24'sh7fffff);
		offer_word(24'shffffff, 24'sh000001);
		offer_word(sample_t'(1193046), sample_t'(-654321));

		// hold three words, then halve the distance each word, half link
		configure(3, 32768, 32768);
		offer_word(sample_t'(4194304), sample_t'(1048576));
		repeat (4) offer_word(24'sh000000, 24'sh000000);
		offer_word(24'shffffff, sample_t'(2097152));

		// slowest release: a small gap rounds to a zero step and the peak stalls
		configure(0, 1, 0);
		offer_word(sample_t'(256), sample_t'(256));
		offer_word(24'sh000000, 24'sh000000);
		offer_word(24'sh7fffff, 24'sh000000);
		offer_word(24'sh000000, 24'sh000000);

		// coefficients above one saturate; the unused index must change nothing
		configure(2, 131071, 131071);
		write_reg(REG_UNUSED, 131071);
		offer_word(sample_t'(6291456), sample_t'(1048576));
		repeat (3) offer_word(24'sh000000, 24'sh000000);
		offer_word(24'sh800000, 24'sh000000);
		offer_word(24'sh000000, sample_t'(12345));

		// zero release: the peak never falls
		configure(0, 0, 0);
		offer_word(24'sh000000, 24'sh000000);
		offer_word(sample_t'(-100), sample_t'(100));

		for (int p = 0; p < PHASES; p++) begin
			hold_v = (PH_HOLD[p] == RANDOM_PICK) ? $urandom_range(16) : PH_HOLD[p];
			rel_v  = (PH_RELEASE[p] == RANDOM_PICK) ? $urandom_range(131071) : PH_RELEASE[p];
			link_v = (PH_LINK[p] == RANDOM_PICK) ? $urandom_range(131071) : PH_LINK[p];
			configure(hold_v, rel_v, link_v);
			// no idling, sender idle, receiver stalling, both
			case (p % 4)
				0: begin
					send_idle_pct  <= 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct  <= 75;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct  <= 0;
					recv_stall_pct <= 75;
				end
				default: begin
					send_idle_pct  <= 31;
					recv_stall_pct <= 31;
				end
			endcase
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				// receiver holds off while words keep coming, so the input backs up
				if (p == 0 && n == 40)
					hold_off_tog <= ~hold_off_tog;
				// sender pause until the pipe is empty
				if (p == 5 && n == 75)
					settle();
				offer_word(next_sample(0), next_sample(1));
			end
		end

		settle();
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#(RUN_LIMIT_CYCLES * 2 * HALF_PERIOD);
		$display("FAILURE");
		$finish;
	end

endmodule

FILE: files.f
design/sphe_pkg.sv
design/sphe_if.sv
design/stereo_peak_hold_envelope_top.sv
sim/sphe_envelope_checker.sv
sim/stereo_peak_hold_envelope_top_tb.sv
